// ===== sv/pamf_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// pamf_pkg
// Shared widths, codes and types of the polar arc mask and fade unit.
// ---------------------------------------------------------------------------
package pamf_pkg;

    localparam int unsigned ANGLE_W    = 9;
    localparam int unsigned RADIUS_W   = 6;
    localparam int unsigned LEVEL_W    = 8;
    localparam int unsigned MODE_W     = 2;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 9;

    localparam int unsigned FULL_TURN  = 360;

    // angle lifted by one turn, up to two turns
    localparam int unsigned EXT_ANGLE_W = ANGLE_W + 1;
    // signed differences of lifted angles or radii
    localparam int unsigned DIFF_W      = EXT_ANGLE_W + 1;
    // signed difference of two levels
    localparam int unsigned DLEV_W      = LEVEL_W + 1;
    // divider operands: magnitude of dx * dl over magnitude of dd
    localparam int unsigned DVS_W       = DIFF_W;
    localparam int unsigned DVD_W       = DIFF_W + LEVEL_W;
    // signed sum of start level and signed quotient
    localparam int unsigned SUM_W       = DVD_W + 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_SOLID       = 2'd0,
        MODE_FADE_ANGLE  = 2'd1,
        MODE_FADE_RADIUS = 2'd2
    } t_arc_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OUTSIDE   = 2'd0,
        ST_INSIDE    = 2'd1,
        ST_UNCHANGED = 2'd2
    } t_wr_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ARC_MODE     = 3'd0,
        CFG_START_ANGLE  = 3'd1,
        CFG_END_ANGLE    = 3'd2,
        CFG_FROM_LEVEL   = 3'd3,
        CFG_TO_LEVEL     = 3'd4,
        CFG_INNER_RADIUS = 3'd5,
        CFG_OUTER_RADIUS = 3'd6
    } t_cfg_idx;

    // side data that travels with a pixel through the divider
    typedef struct packed {
        t_wr_status         status;
        logic               use_div;
        logic [LEVEL_W-1:0] lvl;
        logic [LEVEL_W-1:0] from_lvl;
        logic               neg;
    } t_div_tag;

endpackage
`default_nettype wire

// ===== sv/pamf_in_if.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// pamf_in_if
// Pixel channel: polar angle and ring radius with valid/ready handshake.
// ---------------------------------------------------------------------------
interface pamf_in_if;
    import pamf_pkg::*;

    logic                valid;
    logic                ready;
    logic [ANGLE_W-1:0]  pixel_angle;
    logic [RADIUS_W-1:0] pixel_radius;

    modport source (output valid, output pixel_angle, output pixel_radius, input ready);
    modport sink   (input valid, input pixel_angle, input pixel_radius, output ready);
endinterface
`default_nettype wire

// ===== sv/pamf_out_if.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// pamf_out_if
// Result channel: write status and level with valid/ready handshake.
// ---------------------------------------------------------------------------
interface pamf_out_if;
    import pamf_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] write_status;
    logic [LEVEL_W-1:0]  level;

    modport source (output valid, output write_status, output level, input ready);
    modport sink   (input valid, input write_status, input level, output ready);
endinterface
`default_nettype wire

// ===== sv/pamf_div.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// pamf_div
// Pipelined restoring divider, one quotient bit per stage, with side tag.
// ---------------------------------------------------------------------------
module pamf_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_vld,
    input  logic [pamf_pkg::DVD_W-1:0]   i_dvd,
    input  logic [pamf_pkg::DVS_W-1:0]   i_dvs,
    input  pamf_pkg::t_div_tag           i_tag,
    output logic                         o_vld,
    output logic [pamf_pkg::DVD_W-1:0]   o_quo,
    output pamf_pkg::t_div_tag           o_tag
);
    import pamf_pkg::*;

    localparam int unsigned NSTG = DVD_W;

    logic             r_vld [NSTG];
    logic [DVD_W-1:0] r_dvd [NSTG];
    logic [DVD_W-1:0] r_quo [NSTG];
    logic [DVS_W-1:0] r_rem [NSTG];
    logic [DVS_W-1:0] r_dvs [NSTG];
    t_div_tag         r_tag [NSTG];

    logic             n_vld [NSTG];
    logic [DVD_W-1:0] n_dvd [NSTG];
    logic [DVD_W-1:0] n_quo [NSTG];
    logic [DVS_W-1:0] n_rem [NSTG];
    logic [DVS_W-1:0] n_dvs [NSTG];
    t_div_tag         n_tag [NSTG];

    logic             s_vld [NSTG];
    logic [DVD_W-1:0] s_dvd [NSTG];
    logic [DVD_W-1:0] s_quo [NSTG];
    logic [DVS_W-1:0] s_rem [NSTG];
    logic [DVS_W-1:0] s_dvs [NSTG];
    t_div_tag         s_tag [NSTG];

    always_comb begin
        s_vld[0] = i_vld;
        s_dvd[0] = i_dvd;
        s_quo[0] = '0;
        s_rem[0] = '0;
        s_dvs[0] = i_dvs;
        s_tag[0] = i_tag;
        for (int k = 1; k < NSTG; k++) begin
            s_vld[k] = r_vld[k-1];
            s_dvd[k] = r_dvd[k-1];
            s_quo[k] = r_quo[k-1];
            s_rem[k] = r_rem[k-1];
            s_dvs[k] = r_dvs[k-1];
            s_tag[k] = r_tag[k-1];
        end
    end

    always_comb begin
        logic [DVS_W:0] trial;
        trial = '0;
        for (int k = 0; k < NSTG; k++) begin
            trial    = {s_rem[k], s_dvd[k][DVD_W-1]};
            n_vld[k] = s_vld[k];
            n_tag[k] = s_tag[k];
            n_dvs[k] = s_dvs[k];
            n_dvd[k] = {s_dvd[k][DVD_W-2:0], 1'b0};
            if (trial >= {1'b0, s_dvs[k]}) begin
                n_rem[k] = DVS_W'(trial - {1'b0, s_dvs[k]});
                n_quo[k] = {s_quo[k][DVD_W-2:0], 1'b1};
            end else begin
                n_rem[k] = trial[DVS_W-1:0];
                n_quo[k] = {s_quo[k][DVD_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '{default: 1'b0};
        end else if (i_en) begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dvd <= n_dvd;
            r_quo <= n_quo;
            r_rem <= n_rem;
            r_dvs <= n_dvs;
            r_tag <= n_tag;
        end
    end

    assign o_vld = r_vld[NSTG-1];
    assign o_quo = r_quo[NSTG-1];
    assign o_tag = r_tag[NSTG-1];

endmodule
`default_nettype wire

// ===== sv/polar_arc_mask_fade_unit.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// polar_arc_mask_fade_unit
// Arc membership and solid, angle-fade or radius-fade level per pixel.
// ---------------------------------------------------------------------------
// Accepts one pixel per clock while the output is not stalled and returns one
// result per pixel, in order. Each result passes
// 22 register stages: one for the arc test and differences, one for the
// multiply, 19 for the one-bit-per-stage divider that forms the linear map,
// and the output register. A stalled output freezes the whole pipeline;
// pixel ready is high whenever the output register is empty or being taken.
// Write configuration only while the pipeline is empty.
// ---------------------------------------------------------------------------
module polar_arc_mask_fade_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    pamf_in_if.sink                         i_pix,
    pamf_out_if.source                      o_res,
    input  logic                            i_cfg_we,
    input  logic [pamf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pamf_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import pamf_pkg::*;

    typedef struct packed {
        t_div_tag                  tag;
        logic signed [DIFF_W-1:0]  dx;
        logic signed [DIFF_W-1:0]  dd;
        logic signed [DLEV_W-1:0]  dl;
    } t_s1;

    // configuration
    logic [MODE_W-1:0]   r_mode;
    logic [ANGLE_W-1:0]  r_start;
    logic [ANGLE_W-1:0]  r_end;
    logic [LEVEL_W-1:0]  r_from;
    logic [LEVEL_W-1:0]  r_to;
    logic [RADIUS_W-1:0] r_inner;
    logic [RADIUS_W-1:0] r_outer;
    logic [ANGLE_W-1:0]  w_cfg_angle;

    assign w_cfg_angle = (i_cfg_data > CFG_DATA_W'(FULL_TURN)) ?
                         ANGLE_W'(FULL_TURN) : ANGLE_W'(i_cfg_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_SOLID;
            r_start <= '0;
            r_end   <= ANGLE_W'(FULL_TURN);
            r_from  <= '0;
            r_to    <= '1;
            r_inner <= '0;
            r_outer <= '1;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ARC_MODE:     r_mode  <= i_cfg_data[MODE_W-1:0];
                CFG_START_ANGLE:  r_start <= w_cfg_angle;
                CFG_END_ANGLE:    r_end   <= w_cfg_angle;
                CFG_FROM_LEVEL:   r_from  <= i_cfg_data[LEVEL_W-1:0];
                CFG_TO_LEVEL:     r_to    <= i_cfg_data[LEVEL_W-1:0];
                CFG_INNER_RADIUS: r_inner <= i_cfg_data[RADIUS_W-1:0];
                CFG_OUTER_RADIUS: r_outer <= i_cfg_data[RADIUS_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline advance
    logic r_out_vld;
    logic w_en;

    assign w_en        = !r_out_vld || o_res.ready;
    assign i_pix.ready = w_en;

    // stage 1: arc test and differences
    logic                   w_wrap;
    logic [EXT_ANGLE_W-1:0] w_ang;
    logic [EXT_ANGLE_W-1:0] w_s;
    logic [EXT_ANGLE_W-1:0] w_a;
    logic [EXT_ANGLE_W-1:0] w_hi;
    logic                   w_in_open;
    logic                   w_in_closed;
    logic                   w_in_lift;
    logic                   w_in_solid_wrap;
    logic                   w_inside;
    logic                   w_fade;
    t_s1                    n_s1;
    t_s1                    r_s1;
    logic                   r_s1_vld;

    assign w_wrap = !(r_end > r_start);
    assign w_ang  = EXT_ANGLE_W'(i_pix.pixel_angle);
    assign w_s    = EXT_ANGLE_W'(r_start);
    assign w_a    = (w_wrap && (i_pix.pixel_angle <= r_end)) ?
                    w_ang + EXT_ANGLE_W'(FULL_TURN) : w_ang;
    assign w_hi   = w_wrap ? EXT_ANGLE_W'(r_end) + EXT_ANGLE_W'(FULL_TURN)
                           : EXT_ANGLE_W'(r_end);

    assign w_in_open       = (i_pix.pixel_angle > r_start) && (i_pix.pixel_angle < r_end);
    assign w_in_closed     = (i_pix.pixel_angle >= r_start) && (i_pix.pixel_angle <= r_end);
    assign w_in_lift       = (w_a >= w_s) && (w_a <= w_hi);
    assign w_in_solid_wrap = (i_pix.pixel_angle >= r_start) || (i_pix.pixel_angle <= r_end);

    always_comb begin
        n_s1.dl = $signed({1'b0, r_to}) - $signed({1'b0, r_from});
        case (t_arc_mode'(r_mode))
            MODE_FADE_ANGLE: begin
                w_fade   = 1'b1;
                w_inside = w_wrap ? w_in_lift : w_in_open;
                n_s1.dx  = $signed({1'b0, w_a}) - $signed({1'b0, w_s});
                n_s1.dd  = $signed({1'b0, w_hi}) - $signed({1'b0, w_s});
            end
            MODE_FADE_RADIUS: begin
                w_fade   = 1'b1;
                w_inside = w_wrap ? w_in_lift : w_in_closed;
                n_s1.dx  = $signed({{(DIFF_W-RADIUS_W){1'b0}}, i_pix.pixel_radius})
                         - $signed({{(DIFF_W-RADIUS_W){1'b0}}, r_inner});
                n_s1.dd  = $signed({{(DIFF_W-RADIUS_W){1'b0}}, r_outer})
                         - $signed({{(DIFF_W-RADIUS_W){1'b0}}, r_inner});
            end
            default: begin
                w_fade   = 1'b0;
                w_inside = w_wrap ? w_in_solid_wrap : w_in_open;
                n_s1.dx  = '0;
                n_s1.dd  = '0;
            end
        endcase

        n_s1.tag.from_lvl = r_from;
        n_s1.tag.neg      = 1'b0;
        n_s1.tag.use_div  = 1'b0;
        n_s1.tag.lvl      = '0;
        if (r_start == r_end) begin
            n_s1.tag.status = ST_UNCHANGED;
        end else if (!w_inside) begin
            n_s1.tag.status = ST_OUTSIDE;
        end else begin
            n_s1.tag.status = ST_INSIDE;
            if (!w_fade) begin
                n_s1.tag.lvl = r_to;
            end else if (n_s1.dd == '0) begin
                n_s1.tag.lvl = r_from;
            end else begin
                n_s1.tag.use_div = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_en) begin
            r_s1_vld <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1 <= n_s1;
        end
    end

    // stage 2: magnitudes and product
    logic [DIFF_W-1:0]  w_mag_dx;
    logic [DIFF_W-1:0]  w_mag_dd;
    logic [DLEV_W-1:0]  w_abs_dl;
    t_div_tag           n_s2_tag;
    logic               r_s2_vld;
    logic [DVD_W-1:0]   r_s2_dvd;
    logic [DVS_W-1:0]   r_s2_dvs;
    t_div_tag           r_s2_tag;

    assign w_mag_dx = r_s1.dx[DIFF_W-1] ? DIFF_W'(-r_s1.dx) : DIFF_W'(r_s1.dx);
    assign w_mag_dd = r_s1.dd[DIFF_W-1] ? DIFF_W'(-r_s1.dd) : DIFF_W'(r_s1.dd);
    assign w_abs_dl = r_s1.dl[DLEV_W-1] ? DLEV_W'(-r_s1.dl) : DLEV_W'(r_s1.dl);

    always_comb begin
        n_s2_tag     = r_s1.tag;
        n_s2_tag.neg = r_s1.dx[DIFF_W-1] ^ r_s1.dd[DIFF_W-1] ^ r_s1.dl[DLEV_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (w_en) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_dvd <= DVD_W'(w_mag_dx * w_abs_dl[LEVEL_W-1:0]);
            r_s2_dvs <= w_mag_dd;
            r_s2_tag <= n_s2_tag;
        end
    end

    // divider stages
    logic             w_div_vld;
    logic [DVD_W-1:0] w_div_quo;
    t_div_tag         w_div_tag;

    pamf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_s2_vld),
        .i_dvd   (r_s2_dvd),
        .i_dvs   (r_s2_dvs),
        .i_tag   (r_s2_tag),
        .o_vld   (w_div_vld),
        .o_quo   (w_div_quo),
        .o_tag   (w_div_tag)
    );

    // output stage: apply sign, add start level, saturate, or pass the fixed level
    logic signed [SUM_W-1:0] w_quo_s;
    logic signed [SUM_W-1:0] w_sum;
    logic [LEVEL_W-1:0]      w_sat;
    logic [LEVEL_W-1:0]      n_out_level;
    logic [STATUS_W-1:0]     r_out_status;
    logic [LEVEL_W-1:0]      r_out_level;

    assign w_quo_s = $signed({2'b00, w_div_quo});
    assign w_sum   = $signed({{(SUM_W-LEVEL_W){1'b0}}, w_div_tag.from_lvl})
                   + (w_div_tag.neg ? -w_quo_s : w_quo_s);

    always_comb begin
        if (w_sum[SUM_W-1]) begin
            w_sat = '0;
        end else if (w_sum > $signed(SUM_W'({LEVEL_W{1'b1}}))) begin
            w_sat = '1;
        end else begin
            w_sat = w_sum[LEVEL_W-1:0];
        end
        n_out_level = w_div_tag.use_div ? w_sat : w_div_tag.lvl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_status <= w_div_tag.status;
            r_out_level  <= n_out_level;
        end
    end

    assign o_res.valid        = r_out_vld;
    assign o_res.write_status = r_out_status;
    assign o_res.level        = r_out_level;

`ifndef SYNTHESIS
    a_level_zero_unless_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && (o_res.write_status != ST_INSIDE) |-> o_res.level == '0)
        else $error("level nonzero on a result outside the arc");

    a_unchanged_needs_equal_angles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && (o_res.write_status == ST_UNCHANGED) |-> r_start == r_end)
        else $error("unchanged status with distinct start and end angles");

    a_accept_enters_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix.valid && i_pix.ready |=> r_s1_vld)
        else $error("accepted transaction missing from first stage");

    a_stall_holds_divider: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(w_div_vld) && $stable(w_div_quo))
        else $error("divider advanced during a stall");
`endif

endmodule
`default_nettype wire

// ===== test/pamf_arc_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pamf_arc_checker
// Follows the configuration writes, predicts the write status and level of
// every accepted pixel, and compares the results in order as they leave the
// unit. Hands the failure count and the number of outstanding results back.
// ---------------------------------------------------------------------------
module pamf_arc_checker
    import pamf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pamf_in_if                    i_pix,
    pamf_out_if                   i_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct packed {
        t_wr_status         status;
        logic [LEVEL_W-1:0] level;
    } t_pixel_result;

    logic [MODE_W-1:0] arc_mode;
    int                start_deg;
    int                stop_deg;
    int                from_lvl;
    int                to_lvl;
    int                inner_rad;
    int                outer_rad;
    t_pixel_result     expected_q[$];
    int                fail_cnt = 0;

    function automatic int clamp_turn(input logic [CFG_DATA_W-1:0] v);
        if (v > FULL_TURN) begin
            return FULL_TURN;
        end
        return int'(v);
    endfunction

    function automatic int fade_level(input int x, input int lo, input int hi,
                                      input int from_l, input int to_l);
        int r;
        if (hi == lo) begin
            r = from_l;
        end else begin
            r = from_l + ((x - lo) * (to_l - from_l)) / (hi - lo);
        end
        if (r < 0) begin
            r = 0;
        end
        if (r > 255) begin
            r = 255;
        end
        return r;
    endfunction

    function automatic t_pixel_result arc_level(input logic [ANGLE_W-1:0] ang,
                                                input logic [RADIUS_W-1:0] rad);
        t_pixel_result r;
        int            a;
        int            hi;
        int            lvl;
        logic          in_arc;
        r.status = ST_OUTSIDE;
        r.level  = '0;
        a        = int'(ang);
        hi       = stop_deg;
        lvl      = 0;
        if (start_deg == stop_deg) begin
            r.status = ST_UNCHANGED;
            return r;
        end
        if (arc_mode == MODE_FADE_ANGLE || arc_mode == MODE_FADE_RADIUS) begin
            if (stop_deg > start_deg) begin
                if (arc_mode == MODE_FADE_ANGLE) begin
                    in_arc = (a > start_deg) && (a < stop_deg);
                end else begin
                    in_arc = (a >= start_deg) && (a <= stop_deg);
                end
            end else begin
                if (a <= stop_deg) begin
                    a = a + int'(FULL_TURN);
                end
                hi     = stop_deg + int'(FULL_TURN);
                in_arc = (a >= start_deg) && (a <= hi);
            end
            if (arc_mode == MODE_FADE_ANGLE) begin
                lvl = fade_level(a, start_deg, hi, from_lvl, to_lvl);
            end else begin
                lvl = fade_level(int'(rad), inner_rad, outer_rad, from_lvl, to_lvl);
            end
        end else begin
            if (stop_deg > start_deg) begin
                in_arc = (a > start_deg) && (a < stop_deg);
            end else begin
                in_arc = (a >= start_deg) || (a <= stop_deg);
            end
            lvl = to_lvl;
        end
        if (in_arc) begin
            r.status = ST_INSIDE;
            r.level  = lvl[LEVEL_W-1:0];
        end
        return r;
    endfunction

    task automatic flag_failure(input string msg);
        fail_cnt++;
        if (fail_cnt <= 10) begin
            $display("%0t ns: %s", $time, msg);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_pixel_result want;
        if (!i_rst_n) begin
            arc_mode  = MODE_SOLID;
            start_deg = 0;
            stop_deg  = FULL_TURN;
            from_lvl  = 0;
            to_lvl    = 255;
            inner_rad = 0;
            outer_rad = 63;
            expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ARC_MODE:     arc_mode  = i_cfg_data[MODE_W-1:0];
                    CFG_START_ANGLE:  start_deg = clamp_turn(i_cfg_data);
                    CFG_END_ANGLE:    stop_deg  = clamp_turn(i_cfg_data);
                    CFG_FROM_LEVEL:   from_lvl  = int'(i_cfg_data[LEVEL_W-1:0]);
                    CFG_TO_LEVEL:     to_lvl    = int'(i_cfg_data[LEVEL_W-1:0]);
                    CFG_INNER_RADIUS: inner_rad = int'(i_cfg_data[RADIUS_W-1:0]);
                    CFG_OUTER_RADIUS: outer_rad = int'(i_cfg_data[RADIUS_W-1:0]);
                    default: ;
                endcase
            end
            if (i_pix.valid && i_pix.ready) begin
                expected_q.push_back(arc_level(i_pix.pixel_angle, i_pix.pixel_radius));
            end
            if (i_res.valid && i_res.ready) begin
                if (expected_q.size() == 0) begin
                    flag_failure($sformatf("unexpected result: status %0d level %0d",
                                           i_res.write_status, i_res.level));
                end else begin
                    want = expected_q.pop_front();
                    if (i_res.write_status !== want.status || i_res.level !== want.level) begin
                        flag_failure($sformatf(
                            "mismatch: expected status %0d level %0d, got status %0d level %0d",
                            want.status, want.level, i_res.write_status, i_res.level));
                    end
                end
            end
        end
        o_fail_count <= fail_cnt;
        o_pending    <= expected_q.size();
    end

endmodule

// ===== test/tb_polar_arc_mask_fade_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_polar_arc_mask_fade_unit
// Drives pixels through the arc mask and fade unit under a series of arc
// settings: a directed pass over boundaries, wrap, equal angles, radius span
// corners and every mode, then random settings and pixels under phases of
// sender gaps and receiver stalls. The checker beside the unit does the
// prediction and comparison; this module gives the verdict.
// ---------------------------------------------------------------------------
module tb_polar_arc_mask_fade_unit;
    import pamf_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 30;
    localparam int MODE_SPARE     = 3;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    int idle_pct   = 0;
    int stall_pct  = 0;
    int fail_count;
    int pending;
    int quiet_cycles = 0;
    int start_now  = 0;
    int stop_now   = FULL_TURN;

    pamf_in_if  pix ();
    pamf_out_if res ();

    polar_arc_mask_fade_unit DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_pix      (pix),
        .o_res      (res),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    pamf_arc_checker arc_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_pix        (pix),
        .i_res        (res),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(negedge clk) begin
        res.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((pix.valid && pix.ready) || (res.valid && res.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("TEST FAILED");
                    $finish;
                end
            end
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input int value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= CFG_DATA_W'(value);
        @(negedge clk);
    endtask

    // drain the pipeline, then rewrite every register
    task automatic apply_arc(input int mode, input int s, input int e, input int from_l,
                             input int to_l, input int inner, input int outer);
        pix.valid <= 1'b0;
        while (pending != 0) begin
            @(negedge clk);
        end
        write_reg(CFG_ARC_MODE, mode);
        write_reg(CFG_START_ANGLE, s);
        write_reg(CFG_END_ANGLE, e);
        write_reg(CFG_FROM_LEVEL, from_l);
        write_reg(CFG_TO_LEVEL, to_l);
        write_reg(CFG_INNER_RADIUS, inner);
        write_reg(CFG_OUTER_RADIUS, outer);
        cfg_we    <= 1'b0;
        start_now  = (s > FULL_TURN) ? FULL_TURN : s;
        stop_now   = (e > FULL_TURN) ? FULL_TURN : e;
    endtask

    task automatic send_pixel(input logic [ANGLE_W-1:0] ang, input logic [RADIUS_W-1:0] rad);
        while ($urandom_range(99) < idle_pct) begin
            pix.valid        <= 1'b0;
            pix.pixel_angle  <= ANGLE_W'($urandom);
            pix.pixel_radius <= RADIUS_W'($urandom);
            @(negedge clk);
        end
        pix.valid        <= 1'b1;
        pix.pixel_angle  <= ang;
        pix.pixel_radius <= rad;
        do @(posedge clk); while (!pix.ready);
        @(negedge clk);
    endtask

    function automatic int pick_angle();
        case ($urandom_range(9))
            0:       return 0;
            1:       return FULL_TURN;
            2:       return $urandom_range(511, FULL_TURN + 1);
            default: return $urandom_range(FULL_TURN);
        endcase
    endfunction

    function automatic int pick_level();
        case ($urandom_range(5))
            0:       return 0;
            1:       return 255;
            default: return $urandom_range(255);
        endcase
    endfunction

    initial begin : stimulus
        int mode;
        int s;
        int e;
        int inner;
        int outer;
        int lo;
        int hi;
        int ang;
        pix.valid        = 1'b0;
        pix.pixel_angle  = '0;
        pix.pixel_radius = '0;
        res.ready        = 1'b0;
        cfg_we           = 1'b0;
        cfg_idx          = CFG_ARC_MODE;
        cfg_data         = '0;
        rst_n            = 1'b0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // settings left by reset: solid, full turn
        send_pixel(0, 0);
        send_pixel(FULL_TURN, 63);
        send_pixel(180, 21);
        send_pixel(511, 42);

        apply_arc(MODE_FADE_ANGLE, 300, 60, 10, 250, 0, 63);
        send_pixel(300, 0);
        send_pixel(0, 63);
        send_pixel(60, 5);
        send_pixel(61, 9);
        send_pixel(299, 1);
        send_pixel(400, 33);

        apply_arc(MODE_FADE_RADIUS, 90, 270, 77, 200, 10, 10);
        send_pixel(90, 10);
        send_pixel(270, 0);
        send_pixel(89, 10);

        apply_arc(MODE_FADE_RADIUS, 0, FULL_TURN, 0, 255, 50, 5);
        send_pixel(0, 0);
        send_pixel(FULL_TURN, 63);
        send_pixel(180, 27);

        apply_arc(MODE_SPARE, 200, 100, 255, 128, 0, 63);
        send_pixel(200, 0);
        send_pixel(100, 1);
        send_pixel(150, 2);
        send_pixel(511, 3);

        apply_arc(MODE_FADE_ANGLE, 511, FULL_TURN, 0, 255, 0, 63);
        send_pixel(5, 4);

        apply_arc(MODE_FADE_ANGLE, 0, FULL_TURN, 255, 0, 0, 63);
        send_pixel(1, 0);
        send_pixel(359, 63);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 48; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 48; end
                default: begin idle_pct = 16; stall_pct = 16; end
            endcase
            for (int seg = 0; seg < 4; seg++) begin
                mode = ($urandom_range(7) == 0) ? MODE_SPARE : $urandom_range(2);
                s    = pick_angle();
                e    = ($urandom_range(11) == 0) ? s : pick_angle();
                lo   = $urandom_range(63);
                hi   = $urandom_range(63);
                case ($urandom_range(5))
                    0: begin inner = lo; outer = lo; end
                    1: begin inner = lo; outer = hi; end
                    default: begin
                        inner = (lo < hi) ? lo : hi;
                        outer = (lo < hi) ? hi : lo;
                    end
                endcase
                apply_arc(mode, s, e, pick_level(), pick_level(), inner, outer);
                repeat (110) begin
                    case ($urandom_range(9))
                        0:       ang = start_now + $urandom_range(2) - 1;
                        1:       ang = stop_now + $urandom_range(2) - 1;
                        2:       ang = $urandom_range(511, FULL_TURN + 1);
                        default: ang = $urandom_range(FULL_TURN);
                    endcase
                    send_pixel(ANGLE_W'(ang), RADIUS_W'($urandom_range(63)));
                end
            end
        end

        pix.valid <= 1'b0;
        while (pending != 0) begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/pamf_pkg.sv
sv/pamf_in_if.sv
sv/pamf_out_if.sv
sv/pamf_div.sv
sv/polar_arc_mask_fade_unit.sv
test/pamf_arc_checker.sv
test/tb_polar_arc_mask_fade_unit.sv
